// File: rtl/core/brie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brie_pkg
// Shared types and codes for the byte RISC instruction executor.
// ----------------------------------------------------------------------------
package brie_pkg;

   localparam int NUM_REGS = 16;
   localparam int REG_AW   = 4;

   typedef enum logic [1:0] {
      ACT_EXEC         = 2'd0,
      ACT_PRELOAD_REG  = 2'd1,
      ACT_PRELOAD_DATA = 2'd2,
      ACT_NOP          = 2'd3
   } brie_action_type;

   typedef enum logic [3:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_MUL   = 4'd2,
      OP_INC   = 4'd3,
      OP_AND   = 4'd4,
      OP_OR    = 4'd5,
      OP_XOR   = 4'd6,
      OP_NOT   = 4'd7,
      OP_SHL   = 4'd8,
      OP_SHR   = 4'd9,
      OP_LI    = 4'd10,
      OP_LOAD  = 4'd11,
      OP_STORE = 4'd12,
      OP_JMP   = 4'd13,
      OP_BEQ   = 4'd14,
      OP_HALT  = 4'd15
   } brie_opcode_type;

   typedef enum logic [2:0] {
      CLS_ARITH   = 3'd0,
      CLS_LOGIC   = 3'd1,
      CLS_SHIFT   = 3'd2,
      CLS_MEMORY  = 3'd3,
      CLS_LOADIMM = 3'd4,
      CLS_CONTROL = 3'd5,
      CLS_HALT    = 3'd6,
      CLS_NONE    = 3'd7
   } brie_class_type;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   // Result stage contents
   typedef struct packed {
      logic [7:0]     next_pc;
      logic           report_wr;
      logic           rf_we;
      logic [3:0]     rd;
      logic [7:0]     val;
      logic [1:0]     mem;
      logic [7:0]     addr;
      logic           taken;
      logic           halted;
      brie_class_type cls;
      logic           is_load;
      logic           in_range;
   } brie_stage_type;

endpackage

// File: rtl/core/brie_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brie_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module brie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/byte_risc_instruction_executor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_risc_instruction_executor_unit
// 16-bit instruction executor on 16 byte registers and a byte data store.
//
//   Channel   Ports                                      Direction
//   req       req_valid, req_stall, req_action,           in  (stall out)
//             req_instruction_word, req_preload_index,
//             req_preload_value
//   rsp       rsp_valid, rsp_stall, rsp_next_pc, ...     out (stall in)
//
// One item per cycle sustained while rsp_stall is low. An item is first
// registered into the execute stage, where its register operands are read
// and it is executed, then into the result register, which is presented on
// rsp while the data store read for a load completes.
// Reset is synchronous; the register file is cleared at once through one
// valid bit per register, so no clearing pass is needed.
// rsp_stall holds the result register and, when the execute stage is also
// full, raises req_stall in the same cycle.
// ----------------------------------------------------------------------------
module byte_risc_instruction_executor_unit
   import brie_pkg::*;
#(
   parameter int DATA_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_instruction_word,
   input  logic [7:0]  req_preload_index,
   input  logic [7:0]  req_preload_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [3:0]  rsp_dest_reg,
   output logic [7:0]  rsp_write_value,
   output logic [1:0]  rsp_mem_access,
   output logic [7:0]  rsp_mem_address,
   output logic        rsp_branch_taken,
   output logic        rsp_halted,
   output logic [2:0]  rsp_instr_class
);

   localparam int         DATA_AW    = $clog2(DATA_DEPTH);
   localparam logic [8:0] DATA_LIMIT = 9'(DATA_DEPTH);

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept, s1_moves, rsp_accept;

   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign s1_moves   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_moves;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Execute stage (s1) holding registers
   // ---------------------------------------------------------------------
   brie_action_type s1_action_ff, s1_action_in;
   logic [15:0]     s1_word_ff, s1_word_in;
   logic [7:0]      s1_pidx_ff, s1_pidx_in;
   logic [7:0]      s1_pval_ff, s1_pval_in;

   // Architectural state outside the memories
   logic [7:0]        pc_ff, pc_in;
   logic              halt_ff, halt_in;
   logic [NUM_REGS-1:0] rf_valid_ff, rf_valid_in;

   // Last register write, missed by the read issued on the same edge
   logic             lw_we_ff, lw_we_in;
   logic [REG_AW-1:0] lw_idx_ff, lw_idx_in;
   logic [7:0]       lw_val_ff, lw_val_in;

   brie_stage_type s2_ff, s2_in;

   // ---------------------------------------------------------------------
   // Register file: three copies, one per read operand
   // ---------------------------------------------------------------------
   logic              rf_we;
   logic [REG_AW-1:0] rf_waddr;
   logic [7:0]        rf_wdata;
   logic [REG_AW-1:0] ra_rs1, ra_rs2, ra_rd;
   logic [7:0]        rq_rs1, rq_rs2, rq_rd;

   // Re-read every cycle so a waiting item sees every committed write
   assign ra_rs1 = req_accept ? req_instruction_word[7:4]  : s1_word_ff[7:4];
   assign ra_rs2 = req_accept ? req_instruction_word[3:0]  : s1_word_ff[3:0];
   assign ra_rd  = req_accept ? req_instruction_word[11:8] : s1_word_ff[11:8];

   brie_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf_rs1 (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (ra_rs1),
      .rd_data (rq_rs1)
   );

   brie_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf_rs2 (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (ra_rs2),
      .rd_data (rq_rs2)
   );

   brie_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf_rd (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (ra_rd),
      .rd_data (rq_rd)
   );

   // ---------------------------------------------------------------------
   // Data store
   // ---------------------------------------------------------------------
   logic               dm_we;
   logic [DATA_AW-1:0] dm_waddr, dm_raddr;
   logic [7:0]         dm_wdata, dm_rdata;

   brie_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (dm_raddr),
      .rd_data (dm_rdata)
   );

   // ---------------------------------------------------------------------
   // Result stage write value; a load picks up the data store here
   // ---------------------------------------------------------------------
   logic [7:0] s2_wval;
   assign s2_wval = s2_ff.is_load ? (s2_ff.in_range ? dm_rdata : 8'd0) : s2_ff.val;

   assign rf_we    = rsp_accept && s2_ff.rf_we;
   assign rf_waddr = s2_ff.rd;
   assign rf_wdata = s2_wval;

   // Operand forwarding: pending result first, then last write, then RAM.
   // A register never written reads as zero (R0 is never written).
   function automatic logic [7:0] fwd(
      input logic [REG_AW-1:0]   idx,
      input logic [7:0]          ram_q,
      input logic [NUM_REGS-1:0] vld,
      input logic                pend_we,
      input logic [REG_AW-1:0]   pend_idx,
      input logic [7:0]          pend_val,
      input logic                last_we,
      input logic [REG_AW-1:0]   last_idx,
      input logic [7:0]          last_val
   );
      logic [7:0] r;
      if (pend_we && pend_idx == idx) begin
         r = pend_val;
      end else if (last_we && last_idx == idx) begin
         r = last_val;
      end else if (vld[idx]) begin
         r = ram_q;
      end else begin
         r = 8'd0;
      end
      return r;
   endfunction

   logic              pend_we;
   logic [REG_AW-1:0] s1_rd, s1_rs1, s1_rs2;
   logic [7:0]        opa, opb, opd;

   assign pend_we = rsp_valid_ff && s2_ff.rf_we;
   assign s1_rd   = s1_word_ff[11:8];
   assign s1_rs1  = s1_word_ff[7:4];
   assign s1_rs2  = s1_word_ff[3:0];

   assign opa = fwd(s1_rs1, rq_rs1, rf_valid_ff, pend_we, s2_ff.rd, s2_wval,
                    lw_we_ff, lw_idx_ff, lw_val_ff);
   assign opb = fwd(s1_rs2, rq_rs2, rf_valid_ff, pend_we, s2_ff.rd, s2_wval,
                    lw_we_ff, lw_idx_ff, lw_val_ff);
   assign opd = fwd(s1_rd, rq_rd, rf_valid_ff, pend_we, s2_ff.rd, s2_wval,
                    lw_we_ff, lw_idx_ff, lw_val_ff);

   // ---------------------------------------------------------------------
   // Execute
   // ---------------------------------------------------------------------
   brie_opcode_type s1_op;
   logic            s1_exec;
   logic [15:0]     prod;
   logic [7:0]      seq_pc, maddr;
   logic            maddr_ok, pidx_data_ok, pidx_reg_ok;
   logic            wr;
   logic [7:0]      val;

   assign s1_op        = brie_opcode_type'(s1_word_ff[15:12]);
   assign s1_exec      = (s1_action_ff == ACT_EXEC) && !halt_ff;
   assign prod         = 16'(opa) * 16'(opb);
   assign seq_pc       = pc_ff + 8'd2;
   assign maddr        = opa + {4'd0, s1_rs2};
   assign maddr_ok     = {1'b0, maddr} < DATA_LIMIT;
   assign pidx_data_ok = {1'b0, s1_pidx_ff} < DATA_LIMIT;
   assign pidx_reg_ok  = (s1_pidx_ff[7:4] == 4'd0) && (s1_pidx_ff[3:0] != 4'd0);

   always_comb begin
      s2_in          = '0;
      s2_in.next_pc  = pc_ff;
      s2_in.halted   = halt_ff;
      s2_in.cls      = CLS_NONE;
      s2_in.mem      = MEM_NONE;
      wr             = 1'b0;
      val            = 8'd0;
      dm_we          = 1'b0;
      dm_waddr       = maddr[DATA_AW-1:0];
      dm_wdata       = opd;

      if (s1_exec) begin
         s2_in.next_pc = seq_pc;
         case (s1_op)
            OP_ADD: begin val = opa + opb; wr = 1'b1; s2_in.cls = CLS_ARITH; end
            OP_SUB: begin val = opa - opb; wr = 1'b1; s2_in.cls = CLS_ARITH; end
            OP_MUL: begin val = prod[7:0]; wr = 1'b1; s2_in.cls = CLS_ARITH; end
            OP_INC: begin val = opd + 8'd1; wr = 1'b1; s2_in.cls = CLS_ARITH; end
            OP_AND: begin val = opa & opb; wr = 1'b1; s2_in.cls = CLS_LOGIC; end
            OP_OR:  begin val = opa | opb; wr = 1'b1; s2_in.cls = CLS_LOGIC; end
            OP_XOR: begin val = opa ^ opb; wr = 1'b1; s2_in.cls = CLS_LOGIC; end
            OP_NOT: begin val = ~opa;      wr = 1'b1; s2_in.cls = CLS_LOGIC; end
            OP_SHL: begin
               val = s1_rs2[3] ? 8'd0 : (opa << s1_rs2[2:0]);
               wr = 1'b1; s2_in.cls = CLS_SHIFT;
            end
            OP_SHR: begin
               val = s1_rs2[3] ? 8'd0 : (opa >> s1_rs2[2:0]);
               wr = 1'b1; s2_in.cls = CLS_SHIFT;
            end
            OP_LI: begin val = s1_word_ff[7:0]; wr = 1'b1; s2_in.cls = CLS_LOADIMM; end
            OP_LOAD: begin
               wr             = 1'b1;
               s2_in.cls      = CLS_MEMORY;
               s2_in.mem      = MEM_LOAD;
               s2_in.addr     = maddr;
               s2_in.is_load  = 1'b1;
               s2_in.in_range = maddr_ok;
            end
            OP_STORE: begin
               s2_in.cls  = CLS_MEMORY;
               s2_in.mem  = MEM_STORE;
               s2_in.addr = maddr;
               dm_we      = s1_moves && maddr_ok;
            end
            OP_JMP: begin
               s2_in.next_pc = seq_pc + {s1_word_ff[10:4], 1'b0};
               s2_in.taken   = 1'b1;
               s2_in.cls     = CLS_CONTROL;
            end
            OP_BEQ: begin
               s2_in.cls = CLS_CONTROL;
               if (opd == 8'd0) begin
                  s2_in.next_pc = seq_pc + {s1_word_ff[6:0], 1'b0};
                  s2_in.taken   = 1'b1;
               end
            end
            OP_HALT: begin
               s2_in.halted = 1'b1;
               s2_in.cls    = CLS_HALT;
            end
            default: begin
               s2_in.cls = CLS_NONE;
            end
         endcase
         // writes to R0 are dropped
         if (wr && s1_rd != 4'd0) begin
            s2_in.report_wr = 1'b1;
            s2_in.rf_we     = 1'b1;
            s2_in.rd        = s1_rd;
            s2_in.val       = val;
         end
      end else if (s1_action_ff == ACT_PRELOAD_REG) begin
         s2_in.rf_we = pidx_reg_ok;
         s2_in.rd    = s1_pidx_ff[3:0];
         s2_in.val   = s1_pval_ff;
      end else if (s1_action_ff == ACT_PRELOAD_DATA) begin
         dm_we    = s1_moves && pidx_data_ok;
         dm_waddr = s1_pidx_ff[DATA_AW-1:0];
         dm_wdata = s1_pval_ff;
      end
   end

   // a waiting load keeps re-reading its own address
   assign dm_raddr = s1_moves ? maddr[DATA_AW-1:0] : s2_ff.addr[DATA_AW-1:0];

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_moves);
      rsp_valid_in = s1_moves || (rsp_valid_ff && !rsp_accept);

      s1_action_in = s1_action_ff;
      s1_word_in   = s1_word_ff;
      s1_pidx_in   = s1_pidx_ff;
      s1_pval_in   = s1_pval_ff;
      if (req_accept) begin
         s1_action_in = brie_action_type'(req_action);
         s1_word_in   = req_instruction_word;
         s1_pidx_in   = req_preload_index;
         s1_pval_in   = req_preload_value;
      end

      pc_in   = (s1_moves && s1_exec) ? s2_in.next_pc : pc_ff;
      halt_in = halt_ff || (s1_moves && s1_exec && s1_op == OP_HALT);

      rf_valid_in = rf_valid_ff;
      if (rf_we) begin
         rf_valid_in[rf_waddr] = 1'b1;
      end

      lw_we_in  = rf_we;
      lw_idx_in = rf_waddr;
      lw_val_in = rf_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= 8'd0;
         halt_ff      <= 1'b0;
         rf_valid_ff  <= '0;
         lw_we_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         rf_valid_ff  <= rf_valid_in;
         lw_we_ff     <= lw_we_in;
      end
      s1_action_ff <= s1_action_in;
      s1_word_ff   <= s1_word_in;
      s1_pidx_ff   <= s1_pidx_in;
      s1_pval_ff   <= s1_pval_in;
      lw_idx_ff    <= lw_idx_in;
      lw_val_ff    <= lw_val_in;
      if (s1_moves) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result outputs
   // ---------------------------------------------------------------------
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = s2_ff.next_pc;
   assign rsp_reg_written  = s2_ff.report_wr;
   assign rsp_dest_reg     = s2_ff.report_wr ? s2_ff.rd : 4'd0;
   assign rsp_write_value  = s2_ff.report_wr ? s2_wval : 8'd0;
   assign rsp_mem_access   = s2_ff.mem;
   assign rsp_mem_address  = s2_ff.addr;
   assign rsp_branch_taken = s2_ff.taken;
   assign rsp_halted       = s2_ff.halted;
   assign rsp_instr_class  = s2_ff.cls;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> rf_waddr != 4'd0)
      else $error("register write to R0");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with a free stage");

   a_taken_control: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_taken |-> rsp_instr_class == CLS_CONTROL)
      else $error("branch taken outside control class");

   a_pc_frozen: assert property (@(posedge clock) disable iff (reset)
      !s1_moves |=> pc_ff == $past(pc_ff))
      else $error("pc changed without an item leaving execute");

endmodule
